// ===== rtl/rvid_pkg.sv =====
// Package for the RV32I instruction decoder: opcode and word constants,
// the dense operation code type and the decoded item struct.
// No dependencies.
package rvid_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned OutDataWidth = 80;

   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [31:0] WORD_ECALL = 32'h0000_0073;
   localparam logic [31:0] WORD_MRET  = 32'h3020_0073;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   typedef enum logic [5:0] {
      OP_UNKNOWN = 6'd0,
      OP_LB      = 6'd1,
      OP_LH      = 6'd2,
      OP_LW      = 6'd3,
      OP_LBU     = 6'd4,
      OP_LHU     = 6'd5,
      OP_ADD     = 6'd6,
      OP_SUB     = 6'd7,
      OP_SLL     = 6'd8,
      OP_SLT     = 6'd9,
      OP_SLTU    = 6'd10,
      OP_XOR     = 6'd11,
      OP_SRL     = 6'd12,
      OP_SRA     = 6'd13,
      OP_OR      = 6'd14,
      OP_AND     = 6'd15,
      OP_ADDI    = 6'd16,
      OP_SLTI    = 6'd17,
      OP_SLTIU   = 6'd18,
      OP_XORI    = 6'd19,
      OP_ORI     = 6'd20,
      OP_ANDI    = 6'd21,
      OP_SLLI    = 6'd22,
      OP_SRLI    = 6'd23,
      OP_SRAI    = 6'd24,
      OP_SB      = 6'd25,
      OP_SH      = 6'd26,
      OP_SW      = 6'd27,
      OP_BEQ     = 6'd28,
      OP_BNE     = 6'd29,
      OP_BLT     = 6'd30,
      OP_BGE     = 6'd31,
      OP_BLTU    = 6'd32,
      OP_BGEU    = 6'd33,
      OP_JAL     = 6'd34,
      OP_JALR    = 6'd35,
      OP_LUI     = 6'd36,
      OP_AUIPC   = 6'd37,
      OP_ECALL   = 6'd38,
      OP_MRET    = 6'd39,
      OP_CSRRW   = 6'd40,
      OP_CSRRS   = 6'd41,
      OP_CSRRC   = 6'd42,
      OP_CSRRWI  = 6'd43,
      OP_CSRRSI  = 6'd44,
      OP_CSRRCI  = 6'd45
   } op_type;

   typedef struct packed {
      logic [11:0] csr_address;
      logic [4:0]  shift_amount;
      logic [31:0] immediate;
      logic [4:0]  src2_reg;
      logic [4:0]  src1_reg;
      logic [4:0]  dest_reg;
      logic [6:0]  major_opcode;
      op_type      operation;
   } decoded_type;

endpackage

// ===== rtl/rv32i_instruction_decoder_core.sv =====
// Top level of the RV32I instruction decoder: input register, decode logic
// and result register with stream handshakes on both sides.
// Depends on rvid_pkg, rvid_imm_gen and rvid_op_decode.
//
//   channel   direction   tdata fields (lowest bit first)
//   req_      in          instr_word
//   rsp_      out         operation, major_opcode, dest_reg, src1_reg, src2_reg,
//                         immediate, shift_amount, csr_address
//
// One item is accepted per cycle unless the result side stalls.
// The path is set by one input register and one result register with the decode
// logic between them. Synchronous reset empties both registers. A stalled result
// holds in the result register and the input register still fills behind it.
module rv32i_instruction_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instr_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // [5:0] operation, [12:6] major_opcode,
                                    // [17:13] dest_reg, [22:18] src1_reg,
                                    // [27:23] src2_reg, [59:28] immediate,
                                    // [64:60] shift_amount, [76:65] csr_address,
                                    // [79:77] zero
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [31:0]           in_word_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rvid_pkg::decoded_type rsp_data_ff;
   rvid_pkg::decoded_type decoded;
   logic                  rsp_load;
   logic                  req_take;
   rvid_pkg::op_type      operation;
   logic [31:0]           immediate;

   rvid_op_decode u_op_decode (
      .instr_word (in_word_ff),
      .operation  (operation)
   );

   rvid_imm_gen u_imm_gen (
      .instr_word (in_word_ff),
      .immediate  (immediate)
   );

   always_comb begin
      decoded.operation    = operation;
      decoded.major_opcode = in_word_ff[6:0];
      decoded.dest_reg     = in_word_ff[11:7];
      decoded.src1_reg     = in_word_ff[19:15];
      decoded.src2_reg     = in_word_ff[24:20];
      decoded.immediate    = immediate;
      decoded.shift_amount = in_word_ff[24:20];
      decoded.csr_address  = in_word_ff[31:20];
   end

   assign rsp_load   = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || rsp_load;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !rsp_load);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_tdata;
      end
      if (rsp_load) begin
         rsp_data_ff <= decoded;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

// ===== rtl/rvid_imm_gen.sv =====
// Immediate generator for the RV32I decoder: picks the I, S, B, J or U
// immediate by major opcode into 32 bits, sign-extending I, S, B and J.
// Depends on rvid_pkg.
module rvid_imm_gen (
   input  logic [31:0] instr_word,
   output logic [31:0] immediate
);

   always_comb begin
      case (instr_word[6:0])
         rvid_pkg::OPC_LOAD, rvid_pkg::OPC_OPIMM, rvid_pkg::OPC_JALR: begin
            immediate = {{20{instr_word[31]}}, instr_word[31:20]};
         end
         rvid_pkg::OPC_STORE: begin
            immediate = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
         end
         rvid_pkg::OPC_BRANCH: begin
            immediate = {{20{instr_word[31]}}, instr_word[7], instr_word[30:25],
                         instr_word[11:8], 1'b0};
         end
         rvid_pkg::OPC_JAL: begin
            immediate = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
                         instr_word[30:21], 1'b0};
         end
         rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC: begin
            immediate = {instr_word[31:12], 12'h000};
         end
         default: begin
            immediate = 32'h0000_0000;
         end
      endcase
   end

endmodule

// ===== rtl/rvid_op_decode.sv =====
// Operation decoder for the RV32I decoder: maps opcode, funct3, funct7 and
// the exact ECALL and MRET words to the dense operation code.
// Depends on rvid_pkg.
module rvid_op_decode (
   input  logic [31:0]     instr_word,
   output rvid_pkg::op_type operation
);

   logic [2:0] funct3;
   logic [6:0] funct7;

   assign funct3 = instr_word[14:12];
   assign funct7 = instr_word[31:25];

   always_comb begin
      operation = rvid_pkg::OP_UNKNOWN;
      case (instr_word[6:0])
         rvid_pkg::OPC_LOAD: begin
            case (funct3)
               3'd0: operation = rvid_pkg::OP_LB;
               3'd1: operation = rvid_pkg::OP_LH;
               3'd2: operation = rvid_pkg::OP_LW;
               3'd4: operation = rvid_pkg::OP_LBU;
               3'd5: operation = rvid_pkg::OP_LHU;
               default: operation = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_STORE: begin
            case (funct3)
               3'd0: operation = rvid_pkg::OP_SB;
               3'd1: operation = rvid_pkg::OP_SH;
               3'd2: operation = rvid_pkg::OP_SW;
               default: operation = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_BRANCH: begin
            case (funct3)
               3'd0: operation = rvid_pkg::OP_BEQ;
               3'd1: operation = rvid_pkg::OP_BNE;
               3'd4: operation = rvid_pkg::OP_BLT;
               3'd5: operation = rvid_pkg::OP_BGE;
               3'd6: operation = rvid_pkg::OP_BLTU;
               3'd7: operation = rvid_pkg::OP_BGEU;
               default: operation = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_OP: begin
            case (funct3)
               3'd0: begin
                  if (funct7 == rvid_pkg::F7_BASE) begin
                     operation = rvid_pkg::OP_ADD;
                  end else if (funct7 == rvid_pkg::F7_ALT) begin
                     operation = rvid_pkg::OP_SUB;
                  end
               end
               3'd1: operation = rvid_pkg::OP_SLL;
               3'd2: operation = rvid_pkg::OP_SLT;
               3'd3: operation = rvid_pkg::OP_SLTU;
               3'd4: operation = rvid_pkg::OP_XOR;
               3'd5: begin
                  if (funct7 == rvid_pkg::F7_BASE) begin
                     operation = rvid_pkg::OP_SRL;
                  end else if (funct7 == rvid_pkg::F7_ALT) begin
                     operation = rvid_pkg::OP_SRA;
                  end
               end
               3'd6: operation = rvid_pkg::OP_OR;
               3'd7: operation = rvid_pkg::OP_AND;
               default: operation = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_OPIMM: begin
            case (funct3)
               3'd0: operation = rvid_pkg::OP_ADDI;
               3'd1: operation = rvid_pkg::OP_SLLI;
               3'd2: operation = rvid_pkg::OP_SLTI;
               3'd3: operation = rvid_pkg::OP_SLTIU;
               3'd4: operation = rvid_pkg::OP_XORI;
               3'd5: begin
                  if (funct7 == rvid_pkg::F7_BASE) begin
                     operation = rvid_pkg::OP_SRLI;
                  end else if (funct7 == rvid_pkg::F7_ALT) begin
                     operation = rvid_pkg::OP_SRAI;
                  end
               end
               3'd6: operation = rvid_pkg::OP_ORI;
               3'd7: operation = rvid_pkg::OP_ANDI;
               default: operation = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_JAL:   operation = rvid_pkg::OP_JAL;
         rvid_pkg::OPC_JALR:  operation = rvid_pkg::OP_JALR;
         rvid_pkg::OPC_LUI:   operation = rvid_pkg::OP_LUI;
         rvid_pkg::OPC_AUIPC: operation = rvid_pkg::OP_AUIPC;
         rvid_pkg::OPC_SYSTEM: begin
            if (instr_word == rvid_pkg::WORD_ECALL) begin
               operation = rvid_pkg::OP_ECALL;
            end else if (instr_word == rvid_pkg::WORD_MRET) begin
               operation = rvid_pkg::OP_MRET;
            end else begin
               case (funct3)
                  3'd1: operation = rvid_pkg::OP_CSRRW;
                  3'd2: operation = rvid_pkg::OP_CSRRS;
                  3'd3: operation = rvid_pkg::OP_CSRRC;
                  3'd5: operation = rvid_pkg::OP_CSRRWI;
                  3'd6: operation = rvid_pkg::OP_CSRRSI;
                  3'd7: operation = rvid_pkg::OP_CSRRCI;
                  default: operation = rvid_pkg::OP_UNKNOWN;
               endcase
            end
         end
         default: begin
            operation = rvid_pkg::OP_UNKNOWN;
         end
      endcase
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rv32i_instruction_decoder_core: streams instruction words
// through the decoder under random idling and checks every decoded item against a predictor.
// Depends on rvid_pkg and the decoder RTL.
module tb;

   localparam int unsigned PhaseCount = 3;
   localparam int unsigned HoldPhase = 2;
   localparam int unsigned HoldCycles = 60;
   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned SettleCycles = 8;
   localparam int unsigned RandomPerPhase = 465;
   localparam int unsigned ReportLimit = 10;
   localparam int unsigned SendIdlePct [PhaseCount] = '{29, 65, 0};
   localparam int unsigned RecvIdlePct [PhaseCount] = '{65, 29, 0};

   localparam rvid_pkg::op_type LoadOps [8] = '{
      rvid_pkg::OP_LB, rvid_pkg::OP_LH, rvid_pkg::OP_LW, rvid_pkg::OP_UNKNOWN,
      rvid_pkg::OP_LBU, rvid_pkg::OP_LHU, rvid_pkg::OP_UNKNOWN, rvid_pkg::OP_UNKNOWN};
   localparam rvid_pkg::op_type StoreOps [8] = '{
      rvid_pkg::OP_SB, rvid_pkg::OP_SH, rvid_pkg::OP_SW, rvid_pkg::OP_UNKNOWN,
      rvid_pkg::OP_UNKNOWN, rvid_pkg::OP_UNKNOWN, rvid_pkg::OP_UNKNOWN, rvid_pkg::OP_UNKNOWN};
   localparam rvid_pkg::op_type BranchOps [8] = '{
      rvid_pkg::OP_BEQ, rvid_pkg::OP_BNE, rvid_pkg::OP_UNKNOWN, rvid_pkg::OP_UNKNOWN,
      rvid_pkg::OP_BLT, rvid_pkg::OP_BGE, rvid_pkg::OP_BLTU, rvid_pkg::OP_BGEU};
   localparam rvid_pkg::op_type RegOps [8] = '{
      rvid_pkg::OP_ADD, rvid_pkg::OP_SLL, rvid_pkg::OP_SLT, rvid_pkg::OP_SLTU,
      rvid_pkg::OP_XOR, rvid_pkg::OP_SRL, rvid_pkg::OP_OR, rvid_pkg::OP_AND};
   localparam rvid_pkg::op_type ImmOps [8] = '{
      rvid_pkg::OP_ADDI, rvid_pkg::OP_SLLI, rvid_pkg::OP_SLTI, rvid_pkg::OP_SLTIU,
      rvid_pkg::OP_XORI, rvid_pkg::OP_SRLI, rvid_pkg::OP_ORI, rvid_pkg::OP_ANDI};
   localparam rvid_pkg::op_type CsrOps [8] = '{
      rvid_pkg::OP_UNKNOWN, rvid_pkg::OP_CSRRW, rvid_pkg::OP_CSRRS, rvid_pkg::OP_CSRRC,
      rvid_pkg::OP_UNKNOWN, rvid_pkg::OP_CSRRWI, rvid_pkg::OP_CSRRSI, rvid_pkg::OP_CSRRCI};
   localparam logic [6:0] KnownOpcodes [10] = '{
      rvid_pkg::OPC_LOAD, rvid_pkg::OPC_OPIMM, rvid_pkg::OPC_AUIPC, rvid_pkg::OPC_STORE,
      rvid_pkg::OPC_OP, rvid_pkg::OPC_LUI, rvid_pkg::OPC_BRANCH, rvid_pkg::OPC_JALR,
      rvid_pkg::OPC_JAL, rvid_pkg::OPC_SYSTEM};
   localparam logic [31:0] DirectedWords [29] = '{
      32'h0000_0000, 32'hFFFF_FFFF, rvid_pkg::WORD_ECALL, rvid_pkg::WORD_MRET,
      32'h0010_0073, 32'h0000_00F3, 32'h3020_1073, 32'hFFFF_F4F3,
      32'h0000_4073, 32'h0FF0_000F, 32'hFFF0_0003, 32'h7FF0_2003,
      32'h0000_3003, 32'h0200_0033, 32'h4000_0033, 32'h4000_5033,
      32'hFE00_1013, 32'h4000_5013, 32'h0200_5013, 32'hFE00_2FA3,
      32'h0000_3023, 32'h8000_0063, 32'h7E00_7FE3, 32'h0000_2063,
      32'h8000_006F, 32'h7FFF_F0EF, 32'h8000_7067, 32'hFFFF_F037,
      32'h0000_1017
   };

   typedef struct packed {
      logic [1:0]  phase;
      logic [31:0] word;
   } pending_instr_type;

   typedef struct packed {
      logic [31:0]           word;
      rvid_pkg::decoded_type fields;
   } decode_due_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   pending_instr_type instr_backlog[$];
   decode_due_type    decodes_due[$];
   logic [1:0]     phase = '0;
   int unsigned    words_in = 0;
   int unsigned    decodes_out = 0;
   int unsigned    quiet_cycles = 0;
   int unsigned    hold_left = 0;
   logic           hold_done = 1'b0;
   int unsigned    hold_start = 0;
   int unsigned    mismatch_count = 0;

   rv32i_instruction_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic rvid_pkg::decoded_type decode_word(input logic [31:0] w);
      rvid_pkg::decoded_type d;
      logic [2:0]  f3;
      logic [6:0]  f7;
      f3 = w[14:12];
      f7 = w[31:25];
      d.major_opcode = w[6:0];
      d.dest_reg = w[11:7];
      d.src1_reg = w[19:15];
      d.src2_reg = w[24:20];
      d.shift_amount = w[24:20];
      d.csr_address = w[31:20];
      d.immediate = '0;
      d.operation = rvid_pkg::OP_UNKNOWN;
      case (w[6:0])
         rvid_pkg::OPC_LOAD: begin
            d.immediate = {{20{w[31]}}, w[31:20]};
            d.operation = LoadOps[f3];
         end
         rvid_pkg::OPC_JALR: begin
            d.immediate = {{20{w[31]}}, w[31:20]};
            d.operation = rvid_pkg::OP_JALR;
         end
         rvid_pkg::OPC_OPIMM: begin
            d.immediate = {{20{w[31]}}, w[31:20]};
            d.operation = ImmOps[f3];
            if (d.operation == rvid_pkg::OP_SRLI) begin
               if (f7 == rvid_pkg::F7_ALT) d.operation = rvid_pkg::OP_SRAI;
               else if (f7 != rvid_pkg::F7_BASE) d.operation = rvid_pkg::OP_UNKNOWN;
            end
         end
         rvid_pkg::OPC_STORE: begin
            d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
            d.operation = StoreOps[f3];
         end
         rvid_pkg::OPC_BRANCH: begin
            d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            d.operation = BranchOps[f3];
         end
         rvid_pkg::OPC_JAL: begin
            d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            d.operation = rvid_pkg::OP_JAL;
         end
         rvid_pkg::OPC_LUI: begin
            d.immediate = {w[31:12], 12'h000};
            d.operation = rvid_pkg::OP_LUI;
         end
         rvid_pkg::OPC_AUIPC: begin
            d.immediate = {w[31:12], 12'h000};
            d.operation = rvid_pkg::OP_AUIPC;
         end
         rvid_pkg::OPC_OP: begin
            d.operation = RegOps[f3];
            if (d.operation == rvid_pkg::OP_ADD || d.operation == rvid_pkg::OP_SRL) begin
               if (f7 == rvid_pkg::F7_ALT) begin
                  d.operation = (d.operation == rvid_pkg::OP_ADD) ? rvid_pkg::OP_SUB :
                                                                     rvid_pkg::OP_SRA;
               end else if (f7 != rvid_pkg::F7_BASE) begin
                  d.operation = rvid_pkg::OP_UNKNOWN;
               end
            end
         end
         rvid_pkg::OPC_SYSTEM: begin
            if (w == rvid_pkg::WORD_ECALL) d.operation = rvid_pkg::OP_ECALL;
            else if (w == rvid_pkg::WORD_MRET) d.operation = rvid_pkg::OP_MRET;
            else d.operation = CsrOps[f3];
         end
         default: begin
            d.operation = rvid_pkg::OP_UNKNOWN;
         end
      endcase
      return d;
   endfunction

   // Mostly well-formed encodings with random operand bits; the rest is noise and
   // copies of the two whole-word system instructions, half of them with one bit flipped.
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      int unsigned pick;
      logic [4:0]  flip_bit;
      w = $urandom();
      pick = $urandom_range(99);
      flip_bit = 5'($urandom_range(31));
      if (pick >= 10 && pick < 16) begin
         w = ($urandom_range(1) != 0) ? rvid_pkg::WORD_ECALL : rvid_pkg::WORD_MRET;
         if ($urandom_range(1) != 0) w[flip_bit] = ~w[flip_bit];
      end else if (pick >= 16) begin
         w[6:0] = KnownOpcodes[$urandom_range(9)];
         if ($urandom_range(3) != 0) begin
            w[31:25] = ($urandom_range(1) != 0) ? rvid_pkg::F7_ALT : rvid_pkg::F7_BASE;
         end
      end
      return w;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got, input logic [31:0] word);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= ReportLimit)
            $display("Mismatch in %s for word %h: expected %h, got %h", field, word, want, got);
      end
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin : driver
      logic              launch;
      pending_instr_type next_item;
      launch = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (instr_backlog.size() != 0) begin
            if (instr_backlog[0].phase != phase) begin
               if (words_in + (req_tvalid && req_tready) ==
                   decodes_out + (rsp_tvalid && rsp_tready))
                  phase <= instr_backlog[0].phase;
            end else begin
               launch = ($urandom_range(99) >= SendIdlePct[phase]);
            end
         end
         req_tvalid <= launch;
         if (launch) begin
            next_item = instr_backlog.pop_front();
            req_tdata <= next_item.word;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && phase == HoldPhase && words_in >= hold_start) begin
         rsp_tready <= 1'b0;
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= RecvIdlePct[phase]);
      end
   end

   always @(posedge clock) begin : monitor
      decode_due_type        want_item;
      decode_due_type        new_item;
      rvid_pkg::decoded_type got;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            decodes_out <= decodes_out + 1;
            if (decodes_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit)
                  $display("Unexpected item on the result side: %h", rsp_tdata);
            end else begin
               want_item = decodes_due.pop_front();
               got = rvid_pkg::decoded_type'(rsp_tdata[76:0]);
               check_field("operation", 32'(want_item.fields.operation),
                           32'(got.operation), want_item.word);
               check_field("major_opcode", 32'(want_item.fields.major_opcode),
                           32'(got.major_opcode), want_item.word);
               check_field("dest_reg", 32'(want_item.fields.dest_reg),
                           32'(got.dest_reg), want_item.word);
               check_field("src1_reg", 32'(want_item.fields.src1_reg),
                           32'(got.src1_reg), want_item.word);
               check_field("src2_reg", 32'(want_item.fields.src2_reg),
                           32'(got.src2_reg), want_item.word);
               check_field("immediate", want_item.fields.immediate, got.immediate,
                           want_item.word);
               check_field("shift_amount", 32'(want_item.fields.shift_amount),
                           32'(got.shift_amount), want_item.word);
               check_field("csr_address", 32'(want_item.fields.csr_address),
                           32'(got.csr_address), want_item.word);
               check_field("padding", '0, 32'(rsp_tdata[79:77]), want_item.word);
            end
         end
         if (req_tvalid && req_tready) begin
            words_in <= words_in + 1;
            new_item.word = req_tdata;
            new_item.fields = decode_word(req_tdata);
            decodes_due.push_back(new_item);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic timed_out;
      foreach (DirectedWords[i])
         instr_backlog.push_back('{phase: 2'd0, word: DirectedWords[i]});
      for (int p = 0; p < PhaseCount; p++) begin
         if (p == HoldPhase) hold_start = instr_backlog.size() + 40;
         for (int i = 0; i < RandomPerPhase; i++)
            instr_backlog.push_back('{phase: p[1:0], word: random_word()});
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (!(instr_backlog.size() == 0 && !req_tvalid && words_in == decodes_out) &&
             quiet_cycles < WatchdogLimit);
      timed_out = (quiet_cycles >= WatchdogLimit);
      if (!timed_out) repeat (SettleCycles) @(posedge clock);

      if (!timed_out && mismatch_count == 0 && decodes_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rvid_pkg.sv
rtl/rvid_imm_gen.sv
rtl/rvid_op_decode.sv
rtl/rv32i_instruction_decoder_core.sv
tb/tb.sv
